[hdl/cfba_pkg.sv]
// ----------------------------------------------------------------------------
// cfba_pkg
// shared types and constants of the can filter bank allocator
// ----------------------------------------------------------------------------
package cfba_pkg;

  localparam int BANK_COUNT = 14;
  localparam int BANK_W     = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int SLOT_LIMIT = 4 * BANK_COUNT;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 144;

  typedef enum logic [2:0] {
    OP_ADD_STD_LIST = 3'd0,
    OP_ADD_EXT_LIST = 3'd1,
    OP_ADD_STD_MASK = 3'd2,
    OP_ADD_EXT_MASK = 3'd3,
    OP_READ         = 3'd4,
    OP_REMOVE       = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [63:0] words;   // mkh, mkl, idh, idl
    logic [3:0]  usage;
    logic [2:0]  cap;
    logic        active;
    logic [1:0]  ms;
  } bank_t;

  typedef struct packed {
    logic [1:0]  ms;
    logic [31:0] two;
    logic [31:0] one;
    logic        hw_write;
    logic        remote_care_out;
    logic        remote_out;
    logic [28:0] mask_out;
    logic [28:0] id_out;
    logic        is_masked;
    logic        is_extended;
    logic [5:0]  slot_out;
    logic [1:0]  status;
  } result_t;

endpackage

[hdl/can_filter_bank_allocator_top.sv]
// ----------------------------------------------------------------------------
// can_filter_bank_allocator_top
// allocates, reads and frees can acceptance filter slots in a bank memory
// ----------------------------------------------------------------------------
// input channel in_*: one operation per transaction, op in in_tuser, the
// operands in in_tdata. output channel out_*: one result per operation.
// bank state sits in a single-port style memory with a registered read;
// each entry carries a valid bit cleared by reset so all banks read as empty.
// adds scan every bank one per cycle in S_SCAN and then enter S_DONE; read
// and remove in range pass through S_LOOK to S_DONE; out-of-range and unknown
// requests go straight to S_DONE. one operation is in flight at a time;
// in_tready is high only in S_IDLE, so the next is accepted once the result
// has been loaded into the output register, even while that result waits. a
// stalled receiver holds the result in place; a following operation that
// finishes meanwhile waits in its final state until the register frees up.
// reset (rst_n low, synchronous) clears all banks and drops out_tvalid.
// ----------------------------------------------------------------------------
module can_filter_bank_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // filter_id, filter_mask, remote_value, remote_care, slot_index, zero pad
  input  logic [cfba_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [2:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, slot_out, is_extended, is_masked, id_out, mask_out, remote_out,
  // remote_care_out, hw_write, hw_word_one, hw_word_two, hw_mode_scale, pad
  output logic [cfba_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int BW = cfba_pkg::BANK_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LOOK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  cfba_pkg::bank_t mem [cfba_pkg::BANK_COUNT];
  logic [cfba_pkg::BANK_COUNT-1:0] vld_r;
  cfba_pkg::bank_t rd_q;
  logic            rd_en;
  logic [BW-1:0]   rd_addr;
  logic            wr_en;
  logic [BW-1:0]   wr_bank;
  cfba_pkg::bank_t wr_data;

  logic [2:0]  op_r;
  logic [28:0] id_r, mask_r;
  logic        rtr_r, care_r;
  logic [5:0]  slot_r;
  logic        range_err_r;
  logic [BW-1:0] chk_r;
  logic        cand_found_r, free_found_r;
  logic [BW-1:0] cand_bank_r, free_bank_r;
  cfba_pkg::bank_t cand_r;
  logic        out_valid_r;
  cfba_pkg::result_t out_r;

  logic        accept, out_free;
  logic        in_range;
  logic [BW-1:0] in_bank;
  logic        cand_hit;

  cfba_pkg::result_t res;
  cfba_pkg::bank_t   nb;
  logic [1:0]  pos;
  logic [15:0] std_e, msk_e, ext_lo, ext_hi, mext_lo, mext_hi;
  logic [15:0] w_idl, w_idh, w_mkl, w_mkh, iw, mw, lo, hi, sw;
  logic        add_ok, do_write;
  logic [BW-1:0] sel_bank;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r};

  assign in_range = ({1'b0, in_tdata[65:60]} < 7'(cfba_pkg::SLOT_LIMIT));
  assign in_bank  = BW'(in_tdata[65:62]);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_r == S_IDLE && accept) begin
      if (in_tuser <= 3'(cfba_pkg::OP_ADD_EXT_MASK)) begin
        rd_en = 1'b1;
      end else if (in_range) begin
        rd_en   = 1'b1;
        rd_addr = in_bank;
      end
    end else if (state_r == S_SCAN && chk_r != BW'(cfba_pkg::BANK_COUNT - 1)) begin
      rd_en   = 1'b1;
      rd_addr = chk_r + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
    if (wr_en) begin
      mem[wr_bank] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_bank] <= 1'b1;
    end
  end

  always_comb begin
    case (op_r)
      cfba_pkg::OP_ADD_STD_LIST:
        cand_hit = rd_q.cap == 3'd4 && rd_q.usage != 4'h0 && rd_q.usage != 4'hf;
      cfba_pkg::OP_ADD_EXT_LIST:
        cand_hit = rd_q.cap == 3'd2 && (rd_q.usage == 4'h1 || rd_q.usage == 4'h2) && rd_q.ms[0];
      cfba_pkg::OP_ADD_STD_MASK:
        cand_hit = rd_q.cap == 3'd2 && (rd_q.usage == 4'h1 || rd_q.usage == 4'h2) && !rd_q.ms[0];
      default: cand_hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser <= 3'(cfba_pkg::OP_ADD_EXT_MASK)) state_nxt = S_SCAN;
          else if ((in_tuser == 3'(cfba_pkg::OP_READ) || in_tuser == 3'(cfba_pkg::OP_REMOVE))
                   && in_range) state_nxt = S_LOOK;
          else state_nxt = S_DONE;
        end
      end
      S_SCAN: if (chk_r == BW'(cfba_pkg::BANK_COUNT - 1)) state_nxt = S_DONE;
      S_LOOK: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cand_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (state_r == S_IDLE && accept) begin
        cand_found_r <= 1'b0;
        free_found_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (cand_hit && !cand_found_r) cand_found_r <= 1'b1;
        if (rd_q.usage == 4'h0 && !free_found_r) free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      op_r        <= in_tuser;
      id_r        <= in_tdata[28:0];
      mask_r      <= in_tdata[57:29];
      rtr_r       <= in_tdata[58];
      care_r      <= in_tdata[59];
      slot_r      <= in_tdata[65:60];
      range_err_r <= !in_range;
      chk_r       <= '0;
      cand_bank_r <= in_bank;
    end else if (state_r == S_SCAN) begin
      chk_r <= chk_r + BW'(1);
      if (cand_hit && !cand_found_r) begin
        cand_r      <= rd_q;
        cand_bank_r <= chk_r;
      end
      if (rd_q.usage == 4'h0 && !free_found_r) free_bank_r <= chk_r;
    end else if (state_r == S_LOOK) begin
      cand_r <= rd_q;
    end
    if (state_r == S_DONE && out_free) out_r <= res;
  end

  always_comb begin
    res      = '0;
    nb       = cand_r;
    pos      = 2'd0;
    add_ok   = 1'b0;
    do_write = 1'b0;
    sel_bank = cand_bank_r;
    std_e    = {id_r[10:0], rtr_r, 4'h0};
    msk_e    = {mask_r[10:0], care_r, 1'b1, 3'h0};
    ext_lo   = {id_r[12:0], 1'b1, rtr_r, 1'b0};
    ext_hi   = id_r[28:13];
    mext_lo  = {mask_r[12:0], 1'b1, care_r, 1'b0};
    mext_hi  = mask_r[28:13];
    w_idl    = cand_r.words[15:0];
    w_idh    = cand_r.words[31:16];
    w_mkl    = cand_r.words[47:32];
    w_mkh    = cand_r.words[63:48];
    iw = '0; mw = '0; lo = '0; hi = '0; sw = '0;
    case (op_r)
      cfba_pkg::OP_ADD_STD_LIST, cfba_pkg::OP_ADD_EXT_LIST,
      cfba_pkg::OP_ADD_STD_MASK, cfba_pkg::OP_ADD_EXT_MASK: begin
        lo = (op_r == 3'(cfba_pkg::OP_ADD_EXT_LIST)) ? ext_lo : std_e;
        hi = (op_r == 3'(cfba_pkg::OP_ADD_EXT_LIST)) ? ext_hi : msk_e;
        if (cand_found_r && op_r != 3'(cfba_pkg::OP_ADD_EXT_MASK)) begin
          add_ok = 1'b1;
          if (op_r == 3'(cfba_pkg::OP_ADD_STD_LIST)) begin
            if (!cand_r.usage[3]) begin
              pos = 2'd0; nb.words[47:32] = std_e;
            end else if (!cand_r.usage[2]) begin
              pos = 2'd1; nb.words[15:0] = std_e;
            end else if (!cand_r.usage[1]) begin
              pos = 2'd2; nb.words[63:48] = std_e;
            end else begin
              pos = 2'd3; nb.words[31:16] = std_e;
            end
            nb.usage = cand_r.usage | (4'h8 >> pos);
          end else if (!cand_r.usage[1]) begin
            pos = 2'd2;
            nb.words[15:0] = lo;
            if (cand_r.ms[0]) nb.words[31:16] = hi;
            else nb.words[47:32] = hi;
            nb.usage = cand_r.usage | 4'h2;
          end else begin
            pos = 2'd3;
            if (cand_r.ms[0]) nb.words[47:32] = lo;
            else nb.words[31:16] = lo;
            nb.words[63:48] = hi;
            nb.usage = cand_r.usage | 4'h1;
          end
        end else if (free_found_r) begin
          add_ok   = 1'b1;
          sel_bank = free_bank_r;
          nb.active = 1'b1;
          case (op_r)
            cfba_pkg::OP_ADD_STD_LIST: begin
              pos = 2'd0; nb.words = {16'h0, std_e, 32'h0};
              nb.usage = 4'h8; nb.cap = 3'd4; nb.ms = 2'd2;
            end
            cfba_pkg::OP_ADD_EXT_LIST: begin
              pos = 2'd2; nb.words = {32'h0, ext_hi, ext_lo};
              nb.usage = 4'h2; nb.cap = 3'd2; nb.ms = 2'd3;
            end
            cfba_pkg::OP_ADD_STD_MASK: begin
              pos = 2'd2; nb.words = {16'hffff, msk_e, 16'h0, std_e};
              nb.usage = 4'h2; nb.cap = 3'd2; nb.ms = 2'd0;
            end
            default: begin
              pos = 2'd3; nb.words = {mext_hi, mext_lo, ext_hi, ext_lo};
              nb.usage = 4'h1; nb.cap = 3'd1; nb.ms = 2'd1;
            end
          endcase
        end
        if (add_ok) begin
          do_write     = 1'b1;
          res.slot_out = 6'({sel_bank, pos});
          res.hw_write = 1'b1;
          res.ms       = nb.ms;
          if (nb.ms[0]) begin
            res.one = nb.words[31:0];
            res.two = nb.words[63:32];
          end else begin
            res.one = {nb.words[47:32], nb.words[15:0]};
            res.two = {nb.words[63:48], nb.words[31:16]};
          end
        end else begin
          res.status = cfba_pkg::ST_NONE;
        end
      end
      cfba_pkg::OP_READ: begin
        res.slot_out = slot_r;
        pos = slot_r[1:0];
        if (range_err_r) begin
          res.status = cfba_pkg::ST_RANGE;
        end else if (!cand_r.active || !cand_r.usage[2'd3 - pos]) begin
          res.status = cfba_pkg::ST_NONE;
        end else begin
          res.is_extended = cand_r.ms[0];
          res.is_masked   = !cand_r.ms[1];
          if (!cand_r.ms[0]) begin
            if (!cand_r.ms[1]) begin
              iw = (pos == 2'd2) ? w_idl : w_idh;
              mw = (pos == 2'd2) ? w_mkl : w_mkh;
              res.id_out          = 29'(iw[15:5]);
              res.remote_out      = iw[4];
              res.mask_out        = 29'(mw[15:5]);
              res.remote_care_out = mw[4];
            end else begin
              case (pos)
                2'd0: sw = w_mkl;
                2'd1: sw = w_idl;
                2'd2: sw = w_mkh;
                default: sw = w_idh;
              endcase
              res.id_out     = 29'(sw[15:5]);
              res.remote_out = sw[4];
            end
          end else begin
            lo = (cand_r.ms[1] && pos != 2'd2) ? w_mkl : w_idl;
            hi = (cand_r.ms[1] && pos != 2'd2) ? w_mkh : w_idh;
            res.id_out     = {hi, lo[15:3]};
            res.remote_out = lo[1];
            if (!cand_r.ms[1]) begin
              res.mask_out        = {w_mkh, w_mkl[15:3]};
              res.remote_care_out = w_mkl[1];
            end
          end
        end
      end
      cfba_pkg::OP_REMOVE: begin
        res.slot_out = slot_r;
        if (range_err_r) begin
          res.status = cfba_pkg::ST_RANGE;
        end else if (!cand_r.active) begin
          res.status = cfba_pkg::ST_NONE;
        end else begin
          do_write = 1'b1;
          nb.usage = cand_r.usage & ~(4'h8 >> slot_r[1:0]);
          if (nb.usage == 4'h0) begin
            nb.active = 1'b0;
            nb.cap    = 3'd0;
          end
        end
      end
      default: res = '0;
    endcase
  end

  assign wr_en   = (state_r == S_DONE) && out_free && do_write;
  assign wr_bank = sel_bank;
  assign wr_data = nb;

endmodule
